FILE: rtl/msra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msra_pkg;

   // default sensor count and fixed field widths
   localparam int NUM_SENSORS_DEFAULT = 4;
   localparam int SENSOR_W            = 2;
   localparam int SAMPLE_W            = 16;
   localparam int DIST_W              = 15;
   localparam int SLOTS_PER_SENSOR    = 3;
   localparam int POS_W               = 2;

   // slot position that means "wrap on the next sample"
   localparam logic [POS_W-1:0] POS_WRAP = 2'd3;
   localparam logic [POS_W-1:0] POS_AFTER_WRAP = 2'd1;

   // missing echo marker, all ones in two's complement
   localparam logic [SAMPLE_W-1:0] MISSING_MARK = 16'hFFFF;

   // reset value of the no-echo distance register
   localparam logic [DIST_W-1:0] NO_ECHO_RESET = 15'd1000;

   // sum widths and reciprocal for the divide by three
   localparam int SUM_W   = SAMPLE_W + 2;
   localparam int USUM_W  = SAMPLE_W + 1;
   localparam int RECIP_SHIFT = 17;
   localparam logic [15:0] RECIP3 = 16'd43691;
   localparam int PROD_W  = USUM_W + 16;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [DIST_W-1:0]   dist_type;

endpackage

`default_nettype wire

FILE: rtl/multi_sensor_range_averager_top.sv
`timescale 1ns / 1ps
`default_nettype none

// three-sample range averager for several sensors
//
// req channel: one word per range sample, sensor number on req_tuser and the
// signed distance on req_tdata (all ones means no echo). rsp channel: one word
// per filtered distance, sensor number on rsp_tuser. csr_we/csr_wdata load the
// distance reported when two or more of the three samples are missing.
//
// each sensor fills three slots; the fourth and every third sample after it
// overwrite slot 0 and produce one result, the others produce none.
//
// a sample is registered in the input register on acceptance, and a
// result-producing sample moves its result into the output register, which
// drives rsp_tvalid, once that register is free. throughput: one word per
// cycle unless a result waits on a full output register, set by the single
// update stage (slot read, add, reciprocal multiply and slot write).
//
// reset clears all write positions and loads the no-echo register with 1000;
// sample slots keep whatever they held and are only read once written.
// when the receiver stalls, the result waits in the output register; samples
// that give no result keep flowing, and a result-producing sample holds in the
// input register until the output register frees up.
module multi_sensor_range_averager_top
   import msra_pkg::*;
#(
   parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // req_tdata: sample_distance [15:0]
   input  wire logic [SAMPLE_W-1:0] req_tdata,
   // req_tuser: sensor_index [1:0]
   input  wire logic [SENSOR_W-1:0] req_tuser,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // rsp_tdata: filtered_distance [14:0], zero [15]
   output logic [15:0]              rsp_tdata,
   // rsp_tuser: result_sensor [1:0]
   output logic [SENSOR_W-1:0]      rsp_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic                csr_we,
   input  wire logic [DIST_W-1:0]   csr_wdata
);

   localparam int SEL_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   // config register
   dist_type no_echo_ff;

   // input register stage
   logic                s1_valid_ff;
   logic [SENSOR_W-1:0] s1_sensor_ff;
   sample_type          s1_sample_ff;

   // per-sensor state
   logic [POS_W-1:0] pos_ff  [NUM_SENSORS];
   sample_type       slot_ff [NUM_SENSORS][SLOTS_PER_SENSOR];

   // output register
   logic                rsp_valid_ff;
   logic [SENSOR_W-1:0] rsp_sensor_ff;
   dist_type            rsp_dist_ff;
   dist_type            rsp_dist_in;

   logic                s1_in_range;
   logic [SEL_W-1:0]    s1_sel;
   logic [POS_W-1:0]    s1_pos;
   logic                s1_has_result;
   logic                out_free;
   logic                s1_adv;
   logic                req_acc;

   sample_type          v0, v1, v2;
   logic                m0, m1, m2;
   logic [1:0]          nmiss;
   logic signed [SUM_W-1:0] sum;
   logic [USUM_W-1:0]   usum;
   logic [PROD_W-1:0]   prod;
   dist_type            avg3, avg2;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_echo_ff <= NO_ECHO_RESET;
      end else if (csr_we) begin
         no_echo_ff <= csr_wdata;
      end
   end

   // sensor lookup
   assign s1_sel        = SEL_W'(s1_sensor_ff);
   assign s1_in_range   = (32'(s1_sensor_ff) < NUM_SENSORS);
   assign s1_pos        = pos_ff[s1_sel];
   assign s1_has_result = s1_in_range && (s1_pos == POS_WRAP);

   // a sample without a result never waits for the output side
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && (!s1_has_result || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_sensor_ff <= req_tuser;
         s1_sample_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SENSORS; s++) begin
            pos_ff[s] <= '0;
         end
      end else if (s1_adv && s1_in_range) begin
         pos_ff[s1_sel] <= s1_has_result ? POS_AFTER_WRAP : s1_pos + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_in_range) begin
         slot_ff[s1_sel][s1_has_result ? 2'd0 : s1_pos] <= s1_sample_ff;
      end
   end

   // filter: the new sample takes slot 0
   assign v0 = s1_sample_ff;
   assign v1 = slot_ff[s1_sel][1];
   assign v2 = slot_ff[s1_sel][2];
   assign m0 = (v0 == MISSING_MARK);
   assign m1 = (v1 == MISSING_MARK);
   assign m2 = (v2 == MISSING_MARK);
   assign nmiss = 2'(m0) + 2'(m1) + 2'(m2);

   assign sum = (m0 ? '0 : SUM_W'($signed(v0)))
              + (m1 ? '0 : SUM_W'($signed(v1)))
              + (m2 ? '0 : SUM_W'($signed(v2)));

   // negative sums clamp to zero, so divide the non-negative value only
   assign usum = sum[SUM_W-1] ? '0 : sum[USUM_W-1:0];
   assign prod = PROD_W'(usum) * PROD_W'(RECIP3);
   assign avg3 = prod[RECIP_SHIFT +: DIST_W];
   assign avg2 = usum[1 +: DIST_W];

   always_comb begin
      case (nmiss)
         2'd0:    rsp_dist_in = avg3;
         2'd1:    rsp_dist_in = avg2;
         default: rsp_dist_in = no_echo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_has_result) begin
         rsp_sensor_ff <= s1_sensor_ff;
         rsp_dist_ff   <= rsp_dist_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sensor_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff};

   // a new result never overwrites one that is still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_has_result) |-> out_free)
      else $error("result register overwritten while stalled");

   // a sample that gives no result is never held back
   a_no_result_flows : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_has_result) |-> req_tready)
      else $error("no-result sample stalled");

   // after a wrap the sensor resumes at slot 1
   a_wrap_pos : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_has_result) |=> (pos_ff[$past(s1_sel)] == POS_AFTER_WRAP))
      else $error("write position not reset after wrap");

   // the output register only fills from a wrapping sample
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_has_result))
      else $error("result appeared without a wrapping sample");

endmodule

`default_nettype wire

FILE: verif/tb_multi_sensor_range_averager_top.sv
`timescale 1ns / 1ps

module tb_multi_sensor_range_averager_top;
   import msra_pkg::*;

   // run shape
   localparam int NUM_SENSORS   = 4;
   localparam int NUM_PHASES    = 6;
   localparam int PHASE_WORDS   = 317;   // random words per phase, about 1900 in all
   localparam int SETTLE_CYCLES = 8;     // wait for words still in flight
   localparam int LONG_HOLD     = 400;   // receiver stall that backs the block up
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int NUM_ROWS      = 23;

   // one directed sample; want is only meaningful when typed is set
   typedef struct packed {
      logic [SENSOR_W-1:0] sensor;
      sample_type          reading;
      logic                typed;
      dist_type            want;
   } directed_row_type;

   // one filtered distance as it should leave the rsp channel
   typedef struct packed {
      logic [SENSOR_W-1:0] sensor;
      dist_type            distance;
   } range_result_type;

   // directed walk on sensor 0 then sensor 3, slot order noted per group
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // fill slots with full scale, then wrap: all three at full scale
      '{2'd0, 16'h7FFF, 1'b0, 15'd0},
      '{2'd0, 16'h7FFF, 1'b0, 15'd0},
      '{2'd0, 16'h7FFF, 1'b0, 15'd0},
      '{2'd0, 16'h7FFF, 1'b1, 15'd32767},
      // all zero
      '{2'd0, 16'h0000, 1'b0, 15'd0},
      '{2'd0, 16'h0000, 1'b0, 15'd0},
      '{2'd0, 16'h0000, 1'b1, 15'd0},
      // every echo missing gives the reset no-echo distance
      '{2'd0, MISSING_MARK, 1'b0, 15'd0},
      '{2'd0, MISSING_MARK, 1'b0, 15'd0},
      '{2'd0, MISSING_MARK, 1'b1, 15'd1000},
      // one missing: average of 300 and 500
      '{2'd0, MISSING_MARK, 1'b0, 15'd0},
      '{2'd0, 16'd500,      1'b0, 15'd0},
      '{2'd0, 16'd300,      1'b1, 15'd400},
      // most negative samples, average saturates at zero
      '{2'd0, 16'h8000, 1'b0, 15'd0},
      '{2'd0, 16'h8000, 1'b0, 15'd0},
      '{2'd0, 16'h8000, 1'b1, 15'd0},
      // one missing with a negative sample: (7 - 2) / 2 truncates to 2
      '{2'd0, MISSING_MARK, 1'b0, 15'd0},
      '{2'd0, 16'd7,        1'b0, 15'd0},
      '{2'd0, 16'hFFFE,     1'b1, 15'd2},
      // two missing on another sensor
      '{2'd3, 16'd5,        1'b0, 15'd0},
      '{2'd3, MISSING_MARK, 1'b0, 15'd0},
      '{2'd3, 16'd9,        1'b0, 15'd0},
      '{2'd3, MISSING_MARK, 1'b1, 15'd1000}
   };

   // dut ports, inputs all known from time zero
   logic                clock;
   logic                reset      = 1'b1;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic [SENSOR_W-1:0] req_tuser  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         rsp_tdata;
   logic [SENSOR_W-1:0] rsp_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_we     = 1'b0;
   logic [DIST_W-1:0]   csr_wdata  = '0;

   // shadow of the block state
   sample_type          sample_window [NUM_SENSORS][SLOTS_PER_SENSOR];
   logic [POS_W-1:0]    next_slot [NUM_SENSORS];
   dist_type            no_echo_shadow;

   // distances still owed by the block, oldest first
   range_result_type    pending_distances [$];

   // traffic shaping, shared with the ready process
   int                  send_idle_pct = 15;
   int                  recv_idle_pct = 45;
   int                  hold_requests = 0;
   int                  hold_served   = 0;
   int                  hold_left     = 0;

   int                  mismatch_count = 0;
   int                  cycle_count    = 0;

   multi_sensor_range_averager_top #(
      .NUM_SENSORS(NUM_SENSORS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 125 MHz clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // average of the three slots of one sensor, missing echoes left out
   function automatic dist_type average_window(input logic [SENSOR_W-1:0] sensor);
      int sum;
      int missing;
      int v;
      int avg;
      sum     = 0;
      missing = 0;
      for (int k = 0; k < SLOTS_PER_SENSOR; k++) begin
         v = $signed(sample_window[sensor][k]);
         if (sample_window[sensor][k] == MISSING_MARK) begin
            missing++;
         end else begin
            sum += v;
         end
      end
      if (missing >= 2) begin
         return no_echo_shadow;
      end
      // int division truncates toward zero
      avg = (missing == 0) ? sum / 3 : sum / 2;
      if (avg < 0) begin
         return '0;
      end
      return dist_type'(avg);
   endfunction

   // store one sample; returns 1 when it wraps slot 0 and yields a distance
   function automatic bit store_sample(input logic [SENSOR_W-1:0] sensor,
                                       input sample_type reading,
                                       output dist_type distance);
      distance = '0;
      if (next_slot[sensor] != POS_WRAP) begin
         sample_window[sensor][next_slot[sensor]] = reading;
         next_slot[sensor] = next_slot[sensor] + 1'b1;
         return 1'b0;
      end
      sample_window[sensor][0] = reading;
      next_slot[sensor] = POS_AFTER_WRAP;
      distance = average_window(sensor);
      return 1'b1;
   endfunction

   // random sample: mostly in range, a fair share of missing echoes,
   // and some raw 16-bit words that reach the negative side
   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         return MISSING_MARK;
      end else if (pick < 65) begin
         return sample_type'($urandom_range(32767));
      end else if (pick < 75) begin
         return sample_type'($urandom_range(15));
      end else if (pick < 80) begin
         return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      end
      return sample_type'($urandom);
   endfunction

   // offer one word on req, wait for the handshake, then predict
   task automatic send_word(input logic [SENSOR_W-1:0] sensor, input sample_type reading,
                            input logic typed, input dist_type typed_want);
      dist_type         distance;
      range_result_type owed;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= sensor;
      req_tdata  <= reading;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (store_sample(sensor, reading, distance)) begin
         owed.sensor   = sensor;
         owed.distance = typed ? typed_want : distance;
         pending_distances.push_back(owed);
      end
   endtask

   // load the no-echo register once the block has gone quiet
   task automatic write_no_echo(input dist_type value);
      while (pending_distances.size() != 0) begin
         @(posedge clock);
      end
      // words that give no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      no_echo_shadow = value;
   endtask

   // rsp ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // rsp checker, compares each accepted word with the oldest owed distance
   always @(posedge clock) begin
      range_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual sensor %0d distance %0d",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_tuser !== want.sensor) begin
               $display("%0t: sensor mismatch, expected %0d actual %0d",
                        $time, want.sensor, rsp_tuser);
               mismatch_count++;
            end
            // bit 15 of rsp_tdata is padding and must stay zero
            if (rsp_tdata !== {1'b0, want.distance}) begin
               $display("%0t: distance mismatch on sensor %0d, expected %0d actual %0d",
                        $time, want.sensor, want.distance, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // main sequence
   initial begin
      dist_type phase_cfg [NUM_PHASES];
      int       drained;

      // shadow reset: positions at slot 0, register at its reset value
      for (int s = 0; s < NUM_SENSORS; s++) begin
         next_slot[s] = '0;
         for (int k = 0; k < SLOTS_PER_SENSOR; k++) begin
            sample_window[s][k] = '0;
         end
      end
      no_echo_shadow = NO_ECHO_RESET;

      // register plan: both extremes, a random value, 1, another random value, then the reset value
      phase_cfg[0] = 15'd0;
      phase_cfg[1] = 15'd32767;
      phase_cfg[2] = dist_type'($urandom_range(32767));
      phase_cfg[3] = 15'd1;
      phase_cfg[4] = dist_type'($urandom_range(32767));
      phase_cfg[5] = NO_ECHO_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, default register, sender 15 and receiver 45 idle
      for (int row = 0; row < NUM_ROWS; row++) begin
         send_word(DIRECTED_ROWS[row].sensor, DIRECTED_ROWS[row].reading,
                   DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
      end
      req_tvalid <= 1'b0;

      // random part, one register setting per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_no_echo(phase_cfg[phase]);
         if (phase < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 45;
         end else if (phase < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long receiver stall while words keep coming, fills the block
         if (phase == 2) begin
            hold_requests++;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(2'($urandom_range(NUM_SENSORS - 1)), random_sample(), 1'b0, '0);
         end
         req_tvalid <= 1'b0;
      end

      // drain
      drained = 0;
      while (pending_distances.size() != 0 && drained < DRAIN_LIMIT) begin
         @(posedge clock);
         drained++;
      end
      if (pending_distances.size() != 0) begin
         $display("%0t: %0d distances never arrived", $time, pending_distances.size());
         mismatch_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/msra_pkg.sv
rtl/multi_sensor_range_averager_top.sv
verif/tb_multi_sensor_range_averager_top.sv
